@@ sv/marker_triangle_pose_finder_macros.svh @@
// assertion macros for the pad pose finder
`ifndef MARKER_TRIANGLE_POSE_FINDER_MACROS_SVH
`define MARKER_TRIANGLE_POSE_FINDER_MACROS_SVH

// property that must hold whenever reset is released
`define MTPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked on the next cycle
`define MTPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/mtpf_pkg.sv @@
// shared types, constants and tables of the pad pose finder
package mtpf_pkg;

    localparam int unsigned DEPTH_DEF    = 64;
    localparam int unsigned ID_WIDTH_DEF = 8;
    localparam int unsigned COORD_W      = 24;
    localparam int unsigned TIME_W       = 32;
    localparam int unsigned YAW_W        = 16;
    localparam int unsigned CNT8_W       = 8;
    localparam int unsigned ITERS        = 24;
    localparam int unsigned ITER_W       = 5;
    localparam int unsigned CW           = 52;
    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd500;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PRUNE_RD, ST_PRUNE_WB, ST_APPEND,
        ST_SCAN_START, ST_SCAN_RD, ST_SCAN_CHK,
        ST_PICK_RD, ST_PICK_CHK,
        ST_GEO_D, ST_GEO_SQ, ST_GEO_SUM, ST_GEO_CMP, ST_GEO_CTR,
        ST_CORDIC, ST_EMIT,
        ST_DEL_RD, ST_DEL_WB, ST_NEXT_TAG, ST_DONE
    } t_state;

    function automatic logic [31:0] atan_entry(input logic [ITER_W-1:0] i);
        case (i)
            5'd0:  atan_entry = 32'h20000000;
            5'd1:  atan_entry = 32'h12E4051E;
            5'd2:  atan_entry = 32'h09FB385B;
            5'd3:  atan_entry = 32'h051111D4;
            5'd4:  atan_entry = 32'h028B0D43;
            5'd5:  atan_entry = 32'h0145D7E1;
            5'd6:  atan_entry = 32'h00A2F61E;
            5'd7:  atan_entry = 32'h00517C55;
            5'd8:  atan_entry = 32'h0028BE53;
            5'd9:  atan_entry = 32'h00145F2F;
            5'd10: atan_entry = 32'h000A2F98;
            5'd11: atan_entry = 32'h000517CC;
            5'd12: atan_entry = 32'h00028BE6;
            5'd13: atan_entry = 32'h000145F3;
            5'd14: atan_entry = 32'h0000A2F9;
            5'd15: atan_entry = 32'h0000517D;
            5'd16: atan_entry = 32'h000028BE;
            5'd17: atan_entry = 32'h0000145F;
            5'd18: atan_entry = 32'h00000A30;
            5'd19: atan_entry = 32'h00000518;
            5'd20: atan_entry = 32'h0000028C;
            5'd21: atan_entry = 32'h00000146;
            5'd22: atan_entry = 32'h000000A3;
            5'd23: atan_entry = 32'h00000051;
            default: atan_entry = 32'h0;
        endcase
    endfunction

endpackage

@@ sv/mtpf_point_ram.sv @@
// point store: one write port, one registered read port
module mtpf_point_ram
    import mtpf_pkg::*;
#(
    parameter int unsigned DEPTH    = DEPTH_DEF,
    parameter int unsigned ID_WIDTH = ID_WIDTH_DEF,
    localparam int unsigned AW = $clog2(DEPTH),
    localparam int unsigned EW = 3*COORD_W + ID_WIDTH + TIME_W
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [EW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [EW-1:0] o_rdata
);
    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/mtpf_cordic.sv @@
// iterative vectoring cordic, one rotation per cycle
module mtpf_cordic
    import mtpf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [COORD_W:0] i_dx,
    input  logic signed [COORD_W:0] i_dy,
    output logic                    o_done,
    output logic [YAW_W-1:0]        o_yaw
);
    logic signed [CW-1:0] r_x, r_y, n_x, n_y;
    logic [31:0]          r_z, n_z;
    logic [ITER_W-1:0]    r_i, n_i;
    logic                 r_busy, n_busy, r_done, n_done;
    logic signed [CW-1:0] xs, ys, x0, y0;
    logic [31:0]          z_rnd;

    always_comb begin
        x0 = CW'(i_dx) <<< 24;
        y0 = CW'(i_dy) <<< 24;
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        n_x = r_x; n_y = r_y; n_z = r_z; n_i = r_i;
        n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1; n_i = '0;
            if (x0 < 0) begin
                n_x = -x0; n_y = -y0; n_z = 32'h80000000;
            end else begin
                n_x = x0; n_y = y0; n_z = '0;
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                n_x = r_x + ys; n_y = r_y - xs; n_z = r_z + atan_entry(r_i);
            end else begin
                n_x = r_x - ys; n_y = r_y + xs; n_z = r_z - atan_entry(r_i);
            end
            n_i = r_i + 1'b1;
            if (r_i == ITER_W'(ITERS - 1)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_i <= n_i;
    end

    assign z_rnd  = r_z + 32'h8000;
    assign o_yaw  = z_rnd[31:16];
    assign o_done = r_done;
endmodule

@@ sv/marker_triangle_pose_finder.sv @@
// top level of the pad pose finder: sequencer around the point store
//
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  point   | i_valid / o_ready + 6 fields    | in
//  pad     | o_valid / i_ready + 7 fields    | out
//  config  | i_cfg_we / i_cfg_wdata (window) | in
//
// one point transaction at a time; each point is appended, and the first
// point of a message adds a prune pass over every stored entry.
// the last point runs the pad search: per distinct id a check of the earlier
// entries and a pick pass, then for three picked points the geometry states
// and, if a pad is found, a cordic run and a delete pass.
// all passes are bound by the single read port of the point store.
// reset is synchronous; the store needs no clearing, only the fill count.
// a stalled pad transaction holds the sequencer in its emit state.
module marker_triangle_pose_finder
    import mtpf_pkg::*;
#(
    parameter int unsigned DEPTH    = DEPTH_DEF,
    parameter int unsigned ID_WIDTH = ID_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [TIME_W-1:0]         i_cfg_wdata,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [COORD_W-1:0] i_x_pos,
    input  logic signed [COORD_W-1:0] i_y_pos,
    input  logic signed [COORD_W-1:0] i_z_pos,
    input  logic [7:0]                i_marker_id,
    input  logic [TIME_W-1:0]         i_arrival_time,
    input  logic                      i_last_in_message,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [7:0]                o_pad_id,
    output logic signed [COORD_W-1:0] o_center_x,
    output logic signed [COORD_W-1:0] o_center_y,
    output logic signed [COORD_W-1:0] o_center_z,
    output logic signed [YAW_W-1:0]   o_yaw,
    output logic [CNT8_W-1:0]         o_dropped_count,
    output logic                      o_last
);
`include "marker_triangle_pose_finder_macros.svh"

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned NW = $clog2(DEPTH + 1);
    localparam int unsigned EW = 3*COORD_W + ID_WIDTH + TIME_W;
    localparam int unsigned SQ = 2*(COORD_W+1);

    // entry layout {x, y, z, tag, stamp}
    localparam int unsigned S_LO = 0;
    localparam int unsigned T_LO = TIME_W;
    localparam int unsigned Z_LO = T_LO + ID_WIDTH;
    localparam int unsigned Y_LO = Z_LO + COORD_W;
    localparam int unsigned X_LO = Y_LO + COORD_W;

    t_state r_state, n_state;

    logic [TIME_W-1:0]  r_window;
    logic [NW-1:0]      r_count, n_count;
    logic               r_open, n_open;
    logic [CNT8_W-1:0]  r_drops, n_drops;

    // pass pointers: read index, write index, first unseen tag index
    logic [NW-1:0]      r_ri, n_ri, r_wi, n_wi, r_ti, n_ti;
    logic [TIME_W-1:0]  r_now, n_now;
    logic [ID_WIDTH-1:0] r_tag, n_tag;
    logic [1:0]         r_sel, n_sel;
    logic               r_found, n_found, r_any, n_any;

    logic signed [COORD_W-1:0] r_px [3];
    logic signed [COORD_W-1:0] r_py [3];
    logic signed [COORD_W-1:0] r_pz [3];
    logic signed [COORD_W-1:0] n_px [3];
    logic signed [COORD_W-1:0] n_py [3];
    logic signed [COORD_W-1:0] n_pz [3];

    logic signed [COORD_W:0]   r_d [9];
    logic [SQ-1:0]             r_q [9];
    logic [SQ+1:0]             r_dab, r_dbc, r_dac;
    logic [1:0]                r_pick, n_pick;
    logic                      r_ok, n_ok;
    logic signed [COORD_W-1:0] r_cx, r_cy, r_cz, n_cx, n_cy, n_cz;
    logic signed [COORD_W:0]   r_fx, r_fy;

    // output register
    logic               r_ovalid, n_ovalid, r_olast, n_olast;
    logic [7:0]         r_oid, n_oid;
    logic [YAW_W-1:0]   r_oyaw, n_oyaw;
    logic [CNT8_W-1:0]  r_odrop, n_odrop;
    logic signed [COORD_W-1:0] r_ocx, r_ocy, r_ocz;

    // memory ports
    logic           m_we;
    logic [AW-1:0]  m_waddr, m_raddr;
    logic [EW-1:0]  m_wdata, m_rdata;

    logic                      c_start, c_done;
    logic [YAW_W-1:0]          c_yaw;

    logic signed [COORD_W-1:0] e_x, e_y, e_z;
    logic [ID_WIDTH-1:0]       e_tag;
    logic [TIME_W-1:0]         e_stamp;
    logic [TIME_W:0]           e_lim;

    logic signed [COORD_W:0]   sx, sy;
    logic signed [COORD_W:0]   cdx, cdy;

    mtpf_point_ram #(.DEPTH(DEPTH), .ID_WIDTH(ID_WIDTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(m_waddr),
        .i_wdata(m_wdata),
        .i_raddr(m_raddr),
        .o_rdata(m_rdata)
    );

    mtpf_cordic u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(c_start),
        .i_dx   (r_fx),
        .i_dy   (r_fy),
        .o_done (c_done),
        .o_yaw  (c_yaw)
    );

    assign e_x     = m_rdata[X_LO +: COORD_W];
    assign e_y     = m_rdata[Y_LO +: COORD_W];
    assign e_z     = m_rdata[Z_LO +: COORD_W];
    assign e_tag   = m_rdata[T_LO +: ID_WIDTH];
    assign e_stamp = m_rdata[S_LO +: TIME_W];
    assign e_lim   = {1'b0, e_stamp} + {1'b0, r_window};
    assign cdx     = sx;
    assign cdy     = sy;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    // geometry pipeline registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == ST_GEO_D) begin
            r_d[0] <= (COORD_W+1)'(r_px[0]) - (COORD_W+1)'(r_px[1]);
            r_d[1] <= (COORD_W+1)'(r_py[0]) - (COORD_W+1)'(r_py[1]);
            r_d[2] <= (COORD_W+1)'(r_pz[0]) - (COORD_W+1)'(r_pz[1]);
            r_d[3] <= (COORD_W+1)'(r_px[1]) - (COORD_W+1)'(r_px[2]);
            r_d[4] <= (COORD_W+1)'(r_py[1]) - (COORD_W+1)'(r_py[2]);
            r_d[5] <= (COORD_W+1)'(r_pz[1]) - (COORD_W+1)'(r_pz[2]);
            r_d[6] <= (COORD_W+1)'(r_px[0]) - (COORD_W+1)'(r_px[2]);
            r_d[7] <= (COORD_W+1)'(r_py[0]) - (COORD_W+1)'(r_py[2]);
            r_d[8] <= (COORD_W+1)'(r_pz[0]) - (COORD_W+1)'(r_pz[2]);
        end
        if (r_state == ST_GEO_SQ) begin
            for (int k = 0; k < 9; k++) begin
                r_q[k] <= SQ'($unsigned(SQ'(r_d[k]) * SQ'(r_d[k])));
            end
        end
        if (r_state == ST_GEO_SUM) begin
            r_dab <= (SQ+2)'(r_q[0]) + (SQ+2)'(r_q[1]) + (SQ+2)'(r_q[2]);
            r_dbc <= (SQ+2)'(r_q[3]) + (SQ+2)'(r_q[4]) + (SQ+2)'(r_q[5]);
            r_dac <= (SQ+2)'(r_q[6]) + (SQ+2)'(r_q[7]) + (SQ+2)'(r_q[8]);
        end
        if (r_state == ST_GEO_CTR) begin
            r_fx <= cdx;
            r_fy <= cdy;
        end
    end

    // sequencer
    always_comb begin
        logic [1:0] p, q, f;
        logic signed [COORD_W:0] hx, hy, hz;
        p = 2'd0; q = 2'd1; f = 2'd2;
        hx = '0; hy = '0; hz = '0;
        n_state = r_state;
        n_count = r_count; n_open = r_open; n_drops = r_drops;
        n_ri = r_ri; n_wi = r_wi; n_ti = r_ti; n_now = r_now;
        n_tag = r_tag; n_sel = r_sel; n_found = r_found; n_any = r_any;
        n_px = r_px; n_py = r_py; n_pz = r_pz;
        n_pick = r_pick; n_ok = r_ok;
        n_cx = r_cx; n_cy = r_cy; n_cz = r_cz;
        n_ovalid = r_ovalid; n_olast = r_olast; n_oid = r_oid;
        n_oyaw = r_oyaw; n_odrop = r_odrop;
        m_we = 1'b0; m_waddr = '0; m_wdata = '0;
        m_raddr = AW'(r_ri);
        c_start = 1'b0;
        o_ready = 1'b0;
        sx = '0; sy = '0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_now = i_arrival_time;
                    n_found = i_last_in_message;
                    n_px[0] = i_x_pos; n_py[0] = i_y_pos; n_pz[0] = i_z_pos;
                    n_tag = ID_WIDTH'(i_marker_id);
                    n_ri = '0; n_wi = '0;
                    if (!r_open) begin
                        n_open = 1'b1;
                        n_state = (r_count == '0) ? ST_APPEND : ST_PRUNE_RD;
                    end else begin
                        n_state = ST_APPEND;
                    end
                end
            end
            ST_PRUNE_RD: begin
                n_state = ST_PRUNE_WB;
            end
            ST_PRUNE_WB: begin
                if (!(e_lim < {1'b0, r_now})) begin
                    m_we = 1'b1; m_waddr = AW'(r_wi); m_wdata = m_rdata;
                    n_wi = r_wi + 1'b1;
                end
                n_ri = r_ri + 1'b1;
                if (r_ri + 1'b1 == r_count) begin
                    n_count = (e_lim < {1'b0, r_now}) ? r_wi : r_wi + 1'b1;
                    n_state = ST_APPEND;
                end else begin
                    n_state = ST_PRUNE_RD;
                end
            end
            ST_APPEND: begin
                if (r_count < NW'(DEPTH)) begin
                    m_we = 1'b1; m_waddr = AW'(r_count);
                    m_wdata = {r_px[0], r_py[0], r_pz[0], r_tag, r_now};
                    n_count = r_count + 1'b1;
                end else if (r_drops != '1) begin
                    n_drops = r_drops + 1'b1;
                end
                n_any = 1'b0;
                n_ti = '0;
                if (r_found) begin
                    n_open = 1'b0;
                    n_state = ST_SCAN_START;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            // next distinct tag is the tag of the first entry at or after r_ti
            // that has no occurrence before it; since processed tags either
            // were deleted or kept, rescan earlier entries for a match
            ST_SCAN_START: begin
                if (r_ti >= r_count) begin
                    n_state = ST_DONE;
                end else begin
                    m_raddr = AW'(r_ti);
                    n_ri = r_ti;
                    n_state = ST_SCAN_RD;
                    n_found = 1'b0;
                end
            end
            ST_SCAN_RD: begin
                // candidate tag read: latch it, then check earlier entries
                n_state = ST_SCAN_CHK;
                n_tag = e_tag;
                n_ri = '0;
                if (r_ti == '0) begin
                    n_state = ST_PICK_RD;
                    n_sel = '0;
                end
            end
            ST_SCAN_CHK: begin
                if (r_ri != '0 && e_tag == r_tag) begin
                    // already handled earlier, try the next entry
                    n_ti = r_ti + 1'b1;
                    n_state = ST_SCAN_START;
                end else if (r_ri + 1'b1 > r_ti) begin
                    n_ri = '0; n_sel = '0;
                    n_state = ST_PICK_RD;
                end else begin
                    n_ri = r_ri + 1'b1;
                end
            end
            ST_PICK_RD: begin
                n_state = ST_PICK_CHK;
            end
            ST_PICK_CHK: begin
                n_state = ST_PICK_RD;
                if (e_tag == r_tag) begin
                    n_px[r_sel] = e_x; n_py[r_sel] = e_y; n_pz[r_sel] = e_z;
                    n_sel = r_sel + 1'b1;
                    if (r_sel == 2'd2) begin
                        n_state = ST_GEO_D;
                    end
                end
                n_ri = r_ri + 1'b1;
                if (n_state == ST_PICK_RD && r_ri + 1'b1 >= r_count) begin
                    n_state = ST_NEXT_TAG;
                end
            end
            ST_GEO_D:   n_state = ST_GEO_SQ;
            ST_GEO_SQ:  n_state = ST_GEO_SUM;
            ST_GEO_SUM: n_state = ST_GEO_CMP;
            ST_GEO_CMP: begin
                n_ok = 1'b1;
                if (r_dab > r_dbc && r_dab > r_dac) begin
                    n_pick = 2'd0;
                end else if (r_dbc > r_dab && r_dbc > r_dac) begin
                    n_pick = 2'd1;
                end else if (r_dac > r_dbc && r_dac > r_dab) begin
                    n_pick = 2'd2;
                end else begin
                    n_ok = 1'b0;
                end
                n_state = ST_GEO_CTR;
            end
            ST_GEO_CTR: begin
                case (r_pick)
                    2'd0:    begin p = 2'd0; q = 2'd1; f = 2'd2; end
                    2'd1:    begin p = 2'd1; q = 2'd2; f = 2'd0; end
                    default: begin p = 2'd0; q = 2'd2; f = 2'd1; end
                endcase
                hx = ((COORD_W+1)'(r_px[p]) + (COORD_W+1)'(r_px[q])) >>> 1;
                hy = ((COORD_W+1)'(r_py[p]) + (COORD_W+1)'(r_py[q])) >>> 1;
                hz = ((COORD_W+1)'(r_pz[p]) + (COORD_W+1)'(r_pz[q])) >>> 1;
                n_cx = hx[COORD_W-1:0]; n_cy = hy[COORD_W-1:0];
                n_cz = hz[COORD_W-1:0];
                sx = (COORD_W+1)'(r_px[f]) - hx;
                sy = (COORD_W+1)'(r_py[f]) - hy;
                if (!r_ok || (sx == '0 && sy == '0)) begin
                    n_state = ST_NEXT_TAG;
                end else begin
                    n_state = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                // first cycle starts the unit, then wait for done
                if (!r_found) begin
                    c_start = 1'b1;
                    n_found = 1'b1;
                end else if (c_done) begin
                    n_oyaw = c_yaw;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // the previous pad is shown only when this one is known,
                // so the last flag can be set; wait for a free slot
                if (!r_ovalid || i_ready) begin
                    n_ovalid = r_any;
                    n_any = 1'b1;
                    n_oid = 8'(r_tag);
                    n_odrop = r_drops;
                    n_olast = 1'b0;
                    n_ri = '0; n_wi = '0;
                    n_state = ST_DEL_RD;
                end
            end
            ST_DEL_RD: n_state = ST_DEL_WB;
            ST_DEL_WB: begin
                if (e_tag != r_tag) begin
                    m_we = 1'b1; m_waddr = AW'(r_wi); m_wdata = m_rdata;
                    n_wi = r_wi + 1'b1;
                end
                n_ri = r_ri + 1'b1;
                if (r_ri + 1'b1 >= r_count) begin
                    n_count = (e_tag != r_tag) ? r_wi + 1'b1 : r_wi;
                    n_state = ST_NEXT_TAG;
                end else begin
                    n_state = ST_DEL_RD;
                end
            end
            ST_NEXT_TAG: begin
                // after a delete the tag is gone, so the same index is next
                if (r_found) begin
                    n_found = 1'b0;
                end else begin
                    n_ti = r_ti + 1'b1;
                end
                n_state = ST_SCAN_START;
            end
            ST_DONE: begin
                if (!r_any) begin
                    n_state = ST_IDLE;
                end else if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_olast = 1'b1;
                    n_any = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // the held pad result, updated when the next one replaces it
    logic [YAW_W-1:0] r_pyaw;
    logic [7:0]       r_pid;
    logic signed [COORD_W-1:0] r_hcx, r_hcy, r_hcz;
    logic [CNT8_W-1:0] r_pdrop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0; r_open <= 1'b0; r_drops <= '0;
            r_ovalid <= 1'b0; r_any <= 1'b0; r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count; r_open <= n_open; r_drops <= n_drops;
            r_ovalid <= n_ovalid; r_any <= n_any; r_found <= n_found;
        end
        r_ri <= n_ri; r_wi <= n_wi; r_ti <= n_ti; r_now <= n_now;
        r_tag <= n_tag; r_sel <= n_sel;
        r_px <= n_px; r_py <= n_py; r_pz <= n_pz;
        r_pick <= n_pick; r_ok <= n_ok;
        r_cx <= n_cx; r_cy <= n_cy; r_cz <= n_cz;
        r_olast <= n_olast; r_oyaw <= n_oyaw;
        if (r_state == ST_EMIT && (!r_ovalid || i_ready)) begin
            // shift pending pad into output slot, new pad becomes pending
            r_ocx <= r_hcx; r_ocy <= r_hcy; r_ocz <= r_hcz;
            r_oid <= r_pid; r_odrop <= r_pdrop;
            r_hcx <= r_cx; r_hcy <= r_cy; r_hcz <= r_cz;
            r_pid <= n_oid; r_pdrop <= n_odrop; r_pyaw <= r_oyaw;
        end else if (r_state == ST_DONE && r_any && (!r_ovalid || i_ready)) begin
            r_ocx <= r_hcx; r_ocy <= r_hcy; r_ocz <= r_hcz;
            r_oid <= r_pid; r_odrop <= r_pdrop;
        end
    end

    // yaw of the slot follows the pending register on every shift
    logic [YAW_W-1:0] r_syaw;
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT || (r_state == ST_DONE && r_any))
            && (!r_ovalid || i_ready)) begin
            r_syaw <= r_pyaw;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_pad_id        = r_oid;
    assign o_center_x      = r_ocx;
    assign o_center_y      = r_ocy;
    assign o_center_z      = r_ocz;
    assign o_yaw           = r_syaw;
    assign o_dropped_count = r_odrop;
    assign o_last          = r_olast;

    `MTPF_ASSERT(a_count_bound, r_count <= NW'(DEPTH), "fill count beyond depth")
    `MTPF_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid, "result lost while stalled")
    `MTPF_ASSERT(a_ready_idle, !o_ready || r_state == ST_IDLE, "ready outside idle")
endmodule
